/* sv/dhtg_pkg.sv */
// ----------------------------------------------------------------------------
// dhtg_pkg
// Shared widths, register indexes, reset values and sine polynomial
// constants for the decaying harmonic tone generator.
// ----------------------------------------------------------------------------
package dhtg_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_COEFF = 2'd2;

  // Field and register widths
  localparam int CNT_W    = 18;
  localparam int STEP_W   = 24;
  localparam int DECAY_W  = 16;
  localparam int ENV_W    = 16;
  localparam int SAMPLE_W = 16;

  // Register reset values
  localparam logic [CNT_W-1:0]   SAMPLE_RATE_RST = 18'd44100;
  localparam logic [STEP_W-1:0]  PHASE_STEP_RST  = 24'd167392;
  localparam logic [DECAY_W-1:0] DECAY_COEFF_RST = 16'd65523;

  localparam logic [ENV_W-1:0] ENV_FULL = 16'hFFFF;

  // Shared multiplier: 18x18 signed
  localparam int MUL_W  = 18;
  localparam int PROD_W = 2 * MUL_W;

  // Sine approximation, angle in units of 2^-17 of a full turn, Q1.15 arithmetic
  localparam int ANG_W = 17;
  localparam int X_W   = 16;
  localparam logic [X_W:0]   QUAD_SPAN = 17'd32768;
  localparam logic [X_W-1:0] SIN_C1    = 16'd51472;
  localparam logic [X_W-1:0] SIN_C3    = 16'd21024;
  localparam logic [X_W-1:0] SIN_C5    = 16'd2320;
  localparam logic [X_W-1:0] SIN_MAX   = 16'd32767;

  // Harmonic sum is divided by 2^SUM_SHIFT
  localparam int SUM_SHIFT = 3;

endpackage

/* sv/dhtg_ram.sv */
// ----------------------------------------------------------------------------
// dhtg_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module dhtg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/decaying_harmonic_tone_generator.sv */
// ----------------------------------------------------------------------------
// decaying_harmonic_tone_generator
// Additive sine synth: harmonics 1..HARMONIC_COUNT of a phase accumulator,
// summed, divided by 8 and scaled by an exponentially decaying envelope.
// ----------------------------------------------------------------------------
//
//  channel   signals                          dir  beat
//  --------  -------------------------------  ---  ---------------------------
//  in        in_valid, in_stall, trigger      in   one sample tick
//  out       out_valid, out_stall, sample_out out  one Q1.15 sample
//  cfg       cfg_valid, cfg_ready,            in   one register write
//            cfg_index, cfg_data
//
//  A tick is accepted only while the sequencer is idle, so the next tick waits
//  until the last one's sample has been written out: one shared 18x18
//  multiplier runs four products per harmonic plus the envelope decay and the
//  final scaling, one per cycle.
//  Note state (counter, phase, envelope) lives in a one-entry RAM; it is read
//  on accept and written back in the last step, and the read of the next
//  item always comes in a later cycle, so no forwarding is needed.
//  Reset is synchronous; a flag marks the state RAM as unwritten so it reads
//  as zero without a clearing pass.
//  A result waiting in the output register does not stop the next accept;
//  the sequencer waits in its last step only if that register is full and stalled.
//
module decaying_harmonic_tone_generator #(
  parameter int SINE_TABLE_DEPTH = 1024,  // power of two, 256..16384
  parameter int PHASE_BITS       = 24,    // 16..32
  parameter int HARMONIC_COUNT   = 4      // 1..8
) (
  input  logic                           clk,
  input  logic                           rst,
  // sample tick
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           trigger,
  // output sample
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [dhtg_pkg::SAMPLE_W-1:0] sample_out,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dhtg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dhtg_pkg::CFG_DATA_W-1:0] cfg_data
);

  import dhtg_pkg::*;

  localparam int LOG2D  = $clog2(SINE_TABLE_DEPTH);
  localparam int HW     = (HARMONIC_COUNT > 1) ? $clog2(HARMONIC_COUNT) : 1;
  localparam int SUM_W  = X_W + 1 + $clog2(HARMONIC_COUNT) + 1;
  localparam int WORD_W = CNT_W + PHASE_BITS + ENV_W;

  localparam logic [HW-1:0] H_LAST = HW'(HARMONIC_COUNT - 1);

  // sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_X     = 4'd2;
  localparam logic [3:0] S_M2    = 4'd3;
  localparam logic [3:0] S_M3    = 4'd4;
  localparam logic [3:0] S_M4    = 4'd5;
  localparam logic [3:0] S_ACC   = 4'd6;
  localparam logic [3:0] S_ENV   = 4'd7;
  localparam logic [3:0] S_SCALE = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  // ---- configuration registers ----
  logic [CNT_W-1:0]   sample_rate;
  logic [STEP_W-1:0]  phase_step;
  logic [DECAY_W-1:0] decay_coeff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= SAMPLE_RATE_RST;
      phase_step  <= PHASE_STEP_RST;
      decay_coeff <= DECAY_COEFF_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SAMPLE_RATE: sample_rate <= cfg_data[CNT_W-1:0];
        CFG_PHASE_STEP:  phase_step  <= cfg_data[STEP_W-1:0];
        CFG_DECAY_COEFF: decay_coeff <= cfg_data[DECAY_W-1:0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // ---- control state ----
  logic [3:0]    state;
  logic [HW-1:0] h_idx;
  logic          init_done;  // state RAM written at least once

  wire in_acc  = in_valid && !in_stall;
  wire out_acc = out_valid && !out_stall;
  wire out_free = !out_valid || !out_stall;

  assign in_stall = (state != S_IDLE);

  // ---- working registers (payload, no reset) ----
  logic                    trig;
  logic [CNT_W-1:0]        counter;
  logic [PHASE_BITS-1:0]   phase_acc;
  logic [PHASE_BITS-1:0]   ph;        // phase of current harmonic
  logic [ENV_W-1:0]        env;
  logic [X_W-1:0]          x;
  logic [X_W-1:0]          x2;
  logic                    neg;       // lower half of the cycle
  logic signed [SUM_W-1:0] sum;
  logic signed [MUL_W-1:0] s_div;
  logic signed [PROD_W-1:0] prod;

  // ---- state RAM ----
  logic [WORD_W-1:0] rd_word;
  logic [WORD_W-1:0] wr_word;
  logic              ram_we;

  dhtg_ram #(
    .WIDTH(WORD_W),
    .DEPTH(1)
  ) u_state_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(1'b0),
    .wdata(wr_word),
    .re   (in_acc),
    .raddr(1'b0),
    .rdata(rd_word)
  );

  logic [CNT_W-1:0]      rd_cnt;
  logic [PHASE_BITS-1:0] rd_phase;
  logic [ENV_W-1:0]      rd_env;

  always_comb begin
    rd_cnt   = '0;
    rd_phase = '0;
    rd_env   = '0;
    if (init_done) begin
      rd_cnt   = rd_word[WORD_W-1 -: CNT_W];
      rd_phase = rd_word[ENV_W +: PHASE_BITS];
      rd_env   = rd_word[ENV_W-1:0];
    end
  end

  // ---- sine angle of the current harmonic ----
  // table index = top LOG2D bits of the phase; angle in units of 2^-17 of a full turn
  logic [ANG_W-1:0] ang;
  logic [X_W-1:0]   x_c;

  assign ang = {ph[PHASE_BITS-1 -: LOG2D], {(ANG_W - LOG2D){1'b0}}};

  always_comb begin
    if (ang[ANG_W-2]) begin
      x_c = X_W'(QUAD_SPAN - {2'b00, ang[ANG_W-3:0]});  // mirrored quadrant
    end else begin
      x_c = {1'b0, ang[ANG_W-3:0]};
    end
  end

  // ---- shared multiplier operand select ----
  logic [X_W-1:0]          x2_c;
  logic [X_W-1:0]          t_c;
  logic [X_W-1:0]          v_c;
  logic [ENV_W-1:0]        env_c;
  logic signed [MUL_W-1:0] mul_a;
  logic signed [MUL_W-1:0] mul_b;

  assign x2_c  = prod[30:15];
  assign t_c   = SIN_C3 - prod[30:15];
  assign v_c   = SIN_C1 - prod[30:15];
  assign env_c = prod[31:16];

  always_comb begin
    case (state)
      S_X: begin
        mul_a = $signed({2'b00, x_c});
        mul_b = $signed({2'b00, x_c});
      end
      S_M2: begin
        mul_a = $signed({2'b00, SIN_C5});
        mul_b = $signed({2'b00, x2_c});
      end
      S_M3: begin
        mul_a = $signed({2'b00, x2});
        mul_b = $signed({2'b00, t_c});
      end
      S_M4: begin
        mul_a = $signed({2'b00, x});
        mul_b = $signed({2'b00, v_c});
      end
      S_ENV: begin
        mul_a = $signed({2'b00, env});
        mul_b = $signed({2'b00, decay_coeff});
      end
      S_SCALE: begin
        mul_a = s_div;
        mul_b = $signed({2'b00, env_c});
      end
      S_OUT: begin
        mul_a = s_div;
        mul_b = $signed({2'b00, env});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // ---- harmonic accumulate ----
  logic [X_W:0]            y_raw;
  logic [X_W-1:0]          y_sat;
  logic signed [SUM_W-1:0] y_term;

  assign y_raw  = prod[31:15];
  assign y_sat  = (y_raw > {1'b0, SIN_MAX}) ? SIN_MAX : y_raw[X_W-1:0];
  assign y_term = neg ? -$signed(SUM_W'(y_sat)) : $signed(SUM_W'(y_sat));

  // sum / 8, rounded toward zero
  logic signed [SUM_W-1:0] sum_adj;
  assign sum_adj = sum + (sum[SUM_W-1] ? SUM_W'((1 << SUM_SHIFT) - 1) : SUM_W'(0));

  // ---- final scale: prod / 65536 toward zero, then saturate ----
  logic signed [PROD_W-1:0] prod_adj;
  logic signed [PROD_W-17:0] q;
  logic signed [SAMPLE_W-1:0] q_sat;

  assign prod_adj = prod + (prod[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
  assign q        = prod_adj[PROD_W-1:16];

  always_comb begin
    if (q > $signed((PROD_W-16)'(32767))) begin
      q_sat = 16'sh7FFF;
    end else if (q < -$signed((PROD_W-16)'(32768))) begin
      q_sat = -16'sh8000;
    end else begin
      q_sat = q[SAMPLE_W-1:0];
    end
  end

  // ---- counter / phase advance for write-back ----
  logic [CNT_W-1:0]      cnt_inc;
  logic                  wrap;
  logic [PHASE_BITS-1:0] step_ext;

  assign cnt_inc  = counter + 1'b1;
  assign wrap     = (cnt_inc >= sample_rate);
  assign step_ext = PHASE_BITS'(phase_step);

  assign wr_word = wrap ? {{CNT_W{1'b0}}, {PHASE_BITS{1'b0}}, env}
                        : {cnt_inc, phase_acc + step_ext, env};
  assign ram_we  = (state == S_OUT) && out_free;

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      init_done <= 1'b0;
      out_valid <= 1'b0;
      h_idx     <= '0;
    end else begin
      // a new beat loads the output register in the same cycle it drains
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_acc) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          h_idx <= '0;
          state <= S_X;
        end
        S_X:   state <= S_M2;
        S_M2:  state <= S_M3;
        S_M3:  state <= S_M4;
        S_M4:  state <= S_ACC;
        S_ACC: begin
          if (h_idx == H_LAST) begin
            state <= S_ENV;
          end else begin
            h_idx <= h_idx + 1'b1;
            state <= S_X;
          end
        end
        S_ENV:   state <= S_SCALE;
        S_SCALE: state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            init_done <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      trig <= trigger;
    end
    case (state)
      S_READ: begin
        counter   <= trig ? '0 : rd_cnt;
        phase_acc <= trig ? '0 : rd_phase;
        ph        <= trig ? '0 : rd_phase;
        env       <= trig ? ENV_FULL : rd_env;
        sum       <= '0;
      end
      S_X: begin
        x   <= x_c;
        neg <= ang[ANG_W-1];
      end
      S_M2: x2 <= x2_c;
      S_ACC: begin
        sum <= sum + y_term;
        ph  <= ph + phase_acc;  // next harmonic: phase * (h+1) mod 2^P
      end
      S_ENV: s_div <= MUL_W'(sum_adj >>> SUM_SHIFT);
      S_SCALE: env <= env_c;
      S_OUT: begin
        if (out_free) begin
          sample_out <= q_sat;
        end
      end
      default: ;
    endcase
  end

endmodule

/* sv/dhtg_checker.sv */
// ----------------------------------------------------------------------------
// dhtg_checker
// Port-level checks for the tone generator, bound to the top level.
// ----------------------------------------------------------------------------
module dhtg_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [dhtg_pkg::SAMPLE_W-1:0] sample_out
);

  import dhtg_pkg::*;

  // items accepted but not yet delivered
  logic [1:0] pending;

  wire in_acc  = in_valid && !in_stall;
  wire out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending <= pending - 1'b1;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample_out))
    else $error("stalled output beat changed");

  // every result belongs to an accepted tick
  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> pending != 2'd0)
    else $error("output beat without accepted input");

  // at most one tick in work plus one waiting result
  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("too many items in flight");

  // one tick at a time: input closes right after an accept
  a_seq: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> in_stall)
    else $error("second tick accepted while busy");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind decaying_harmonic_tone_generator dhtg_checker u_dhtg_checker (.*);

/* bench/tone_sample_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tone_sample_checker
// Watches the tick, sample and register channels of the tone generator,
// predicts every output sample and compares it with what comes out.
// ----------------------------------------------------------------------------
module tone_sample_checker #(
  parameter int TABLE_DEPTH = 1024,
  parameter int PHASE_W     = 24,
  parameter int HARMONICS   = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic                                 trigger,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [dhtg_pkg::SAMPLE_W-1:0] sample_out,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [dhtg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dhtg_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                   mismatches,
  output int                                   outstanding
);
  import dhtg_pkg::*;

  localparam logic [63:0] PHASE_MASK = (64'd1 << PHASE_W) - 64'd1;

  // register copy
  logic [CNT_W-1:0]   rate_reg;
  logic [STEP_W-1:0]  step_reg;
  logic [DECAY_W-1:0] decay_reg;

  // note state
  logic [CNT_W-1:0]   tick_count;
  logic [PHASE_W-1:0] note_phase;
  logic [ENV_W-1:0]   note_env;

  logic signed [SAMPLE_W-1:0] expected_samples[$];

  // quarter-wave polynomial sine, table entry k
  function automatic int sine_entry(input logic [63:0] k);
    logic [63:0] ang;
    logic [31:0] f, x, x2, t, y;
    logic [1:0]  quad;
    begin
      ang  = (k * 64'd131072) / TABLE_DEPTH;
      quad = ang[16:15];
      f    = {17'd0, ang[14:0]};
      x    = quad[0] ? (32'(QUAD_SPAN) - f) : f;
      x2   = (x * x) >> 15;
      t    = 32'(SIN_C3) - ((32'(SIN_C5) * x2) >> 15);
      y    = (x * (32'(SIN_C1) - ((x2 * t) >> 15))) >> 15;
      if (y > 32'(SIN_MAX)) y = 32'(SIN_MAX);
      return quad[1] ? -int'(y) : int'(y);
    end
  endfunction

  // advance the note by one tick and return its sample
  function automatic logic signed [SAMPLE_W-1:0] tone_sample_for_tick(input logic trig);
    logic [63:0] ph, idx;
    int          harm_sum, scaled;
    longint      prod;
    begin
      if (trig) begin
        tick_count = '0;
        note_phase = '0;
        note_env   = ENV_FULL;
      end
      note_env = ENV_W'((32'(note_env) * 32'(decay_reg)) >> 16);

      harm_sum = 0;
      for (int h = 1; h <= HARMONICS; h++) begin
        ph  = (64'(note_phase) * 64'(h)) & PHASE_MASK;
        idx = (ph * 64'(TABLE_DEPTH)) >> PHASE_W;
        harm_sum += sine_entry(idx);
      end
      scaled = harm_sum / (1 << SUM_SHIFT);
      prod   = longint'(scaled) * longint'(note_env);
      prod   = prod / 65536;
      if (prod > 32767)  prod = 32767;
      if (prod < -32768) prod = -32768;

      tick_count = tick_count + 1'b1;
      if (tick_count >= rate_reg) begin
        tick_count = '0;
        note_phase = '0;
      end else begin
        note_phase = note_phase + PHASE_W'(step_reg);
      end
      return prod[SAMPLE_W-1:0];
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rate_reg   = SAMPLE_RATE_RST;
      step_reg   = PHASE_STEP_RST;
      decay_reg  = DECAY_COEFF_RST;
      tick_count = '0;
      note_phase = '0;
      note_env   = '0;
      mismatches = 0;
      expected_samples.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SAMPLE_RATE: rate_reg  = cfg_data[CNT_W-1:0];
          CFG_PHASE_STEP:  step_reg  = cfg_data[STEP_W-1:0];
          CFG_DECAY_COEFF: decay_reg = cfg_data[DECAY_W-1:0];
          default: ;
        endcase
      end
      // a result leaving now belongs to an earlier tick, so compare first
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected sample, expected none, actual %0d",
                   $time, sample_out);
        end else begin
          logic signed [SAMPLE_W-1:0] want;
          want = expected_samples.pop_front();
          if (sample_out !== want) begin
            mismatches++;
            $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                     $time, want, sample_out);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_samples.push_back(tone_sample_for_tick(trigger));
    end
    outstanding = expected_samples.size();
  end

endmodule

/* bench/decaying_harmonic_tone_generator_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decaying_harmonic_tone_generator_test
// Drives sample ticks and register writes into the tone generator, stalls
// the sample channel at random and lets tone_sample_checker judge every beat.
// ----------------------------------------------------------------------------
module decaying_harmonic_tone_generator_test;
  import dhtg_pkg::*;

  localparam int  LATENCY      = 5 * 4 + 5;     // accept to next accept, default build
  localparam int  RANDOM_TICKS = 1000;
  localparam int  CALM_TICKS   = 100;           // tail of the run with no idling
  localparam int  CYCLE_LIMIT  = 400000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic                       trigger;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;

  int mismatches;
  int outstanding;
  int cycle_count = 0;
  int ticks_sent  = 0;
  bit calm        = 0;   // no gaps and no stalls once set
  bit stall_on    = 1;   // receiver allowed to start stall bursts

  decaying_harmonic_tone_generator i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .trigger   (trigger),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample_out(sample_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tone_sample_checker i_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .trigger    (trigger),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: sized from the slowest legal run (max gap + full latency +
  // max stall per tick) and then taken several times over.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Sample receiver: random stall bursts, with stretches where bursts are
  // switched off entirely; none at all in the calm tail.
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 299) == 0) stall_on = !stall_on;
      if (calm) begin
        out_stall  = 1'b0;
        stall_left = 0;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (stall_on && $urandom_range(0, 6) == 0) begin
        out_stall  = 1'b1;
        stall_left = $urandom_range(1, 14) - 1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // One tick beat. Valid stays high afterwards so back-to-back beats never
  // drop it; a gap lowers it first and scrambles the idle payload.
  task automatic send_tick(input logic trig);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 14)) begin
        trigger = 1'($urandom_range(0, 1));
        @(negedge clk);
      end
    end
    in_valid = 1'b1;
    trigger  = trig;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    ticks_sent++;
  endtask

  // Stop sending and wait until every predicted sample has been seen.
  task automatic drain();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Writes all three registers, only once the generator has gone idle.
  // Upper data bits beyond a register's width ride along and must be dropped.
  task automatic program_regs(input logic [CFG_DATA_W-1:0] rate_word,
                              input logic [CFG_DATA_W-1:0] step_word,
                              input logic [CFG_DATA_W-1:0] decay_word,
                              input bit                    with_unused);
    drain();
    if (with_unused) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
    write_reg(CFG_SAMPLE_RATE, rate_word);
    write_reg(CFG_PHASE_STEP, step_word);
    write_reg(CFG_DECAY_COEFF, decay_word);
    cfg_valid = 1'b0;
    cfg_index = CFG_IDX_W'($urandom);
    cfg_data  = CFG_DATA_W'($urandom);
  endtask

  initial begin
    logic [CNT_W-1:0]      rate;
    logic [CFG_DATA_W-1:0] step;
    logic [DECAY_W-1:0]    decay;
    int                    pick, beats, note_len, directed_ticks;
    bit                    trig;

    rst       = 1'b1;
    in_valid  = 1'b0;
    trigger   = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // ---- directed part ----
    // envelope is zero out of reset: silent until the first trigger
    send_tick(1'b0);
    send_tick(1'b0);
    // note at the reset settings
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    // sample rate zero (only high junk bits set), max step, max decay coefficient,
    // plus a write to the unused index that must change nothing
    program_regs(24'hFC0000, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    // sample rate one, half-cycle step, decay to nothing at once
    program_regs(24'd1, 24'h800000, 24'd0, 1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    // short wrap with max step; ticks that are not triggers before a retrigger
    program_regs(24'd3, 24'hFFFFFF, 24'h00FFFF, 1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    // largest counter range, zero step keeps the phase at zero
    program_regs(24'h03FFFF, 24'd0, 24'h00FFFF, 1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    // lowest usual rate, mid decay
    program_regs(24'd8000, 24'h555555, 24'h008000, 1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    directed_ticks = ticks_sent;

    // ---- random part: phases of notes under one register setting ----
    while (ticks_sent < directed_ticks + RANDOM_TICKS) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0:       rate = CNT_W'($urandom_range(0, 1));
        1, 2, 3,
        4, 5:    rate = CNT_W'($urandom_range(2, 200));  // wraps can happen within a phase
        6, 7:    rate = CNT_W'($urandom_range(8000, 192000));
        8:       rate = '1;
        default: rate = CNT_W'($urandom_range(200, 2000));
      endcase

      pick = $urandom_range(0, 9);
      case (pick)
        0:       step = '0;
        1:       step = '1;
        2, 3:    step = CFG_DATA_W'($urandom_range(0, 300000));
        default: step = CFG_DATA_W'($urandom);
      endcase

      pick = $urandom_range(0, 9);
      case (pick)
        0:       decay = '0;
        1:       decay = '1;
        2:       decay = DECAY_W'($urandom);
        default: decay = DECAY_W'($urandom_range(60000, 65535));
      endcase

      program_regs({6'($urandom), rate}, step, {8'($urandom), decay},
                   $urandom_range(0, 3) == 0);

      beats    = $urandom_range(40, 120);
      note_len = $urandom_range(10, 60);
      for (int i = 0; i < beats; i++) begin
        calm = (ticks_sent >= directed_ticks + RANDOM_TICKS - CALM_TICKS);
        if (i == 0)
          trig = ($urandom_range(0, 3) != 0);  // sometimes carry the old note on
        else
          trig = (i % note_len == 0) || ($urandom_range(0, 50) == 0);
        send_tick(trig);
      end
    end

    // ---- end of run ----
    drain();
    repeat (2 * LATENCY) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* decaying_harmonic_tone_generator.f */
sv/dhtg_pkg.sv
sv/dhtg_ram.sv
sv/decaying_harmonic_tone_generator.sv
sv/dhtg_checker.sv
bench/tone_sample_checker.sv
bench/decaying_harmonic_tone_generator_test.sv
